>>> sv/assert_macros.svh
// Assertion macros shared by the rocker key RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle implication violated");

`endif

>>> sv/mrk_pkg.sv
// Types and constants for the motion-to-rocker-key block.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package mrk_pkg;

   // Key and direction codes.
   typedef enum logic [2:0] {
      DIR_NONE  = 3'd0,
      DIR_UP    = 3'd1,
      DIR_DOWN  = 3'd2,
      DIR_LEFT  = 3'd3,
      DIR_RIGHT = 3'd4
   } dir_type;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_ADDR_W-1:0] CSR_MARGIN_MIN   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TILT_RATIO   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_REPEAT_NEED  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_FIRST_LIMIT  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SECOND_LIMIT = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_THIRD_LIMIT  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_FOURTH_LIMIT = 3'd6;

   // Values after reset.
   localparam logic [6:0] RST_MARGIN_MIN   = 7'd4;
   localparam logic [7:0] RST_TILT_RATIO   = 8'd12;
   localparam logic [3:0] RST_REPEAT_NEED  = 4'd2;
   localparam logic [7:0] RST_FIRST_LIMIT  = 8'd12;
   localparam logic [7:0] RST_SECOND_LIMIT = 8'd60;
   localparam logic [7:0] RST_THIRD_LIMIT  = 8'd80;
   localparam logic [7:0] RST_FOURTH_LIMIT = 8'd100;

   // A Y byte of this value carries no motion.
   localparam logic [7:0] DY_NULL = 8'h80;
   // Dominant axis is scaled by this before the tilt compare.
   localparam logic [3:0] TILT_SCALE = 4'd10;
   localparam logic [1:0] STEP_LAST  = 2'd3;
   localparam logic [7:0] CROSS_MAX  = 8'd255;

   typedef struct packed {
      logic [6:0]      margin_min;
      logic [7:0]      tilt_ratio;
      logic [3:0]      repeat_needed;
      logic [3:0][7:0] step_limit;
   } cfg_type;

   // One decoded and classified motion report.
   typedef struct packed {
      logic       clear;     // ask the sensor to clear its motion register
      logic       act;       // report is large enough to be tracked
      dir_type    cur;       // classified direction
      logic [7:0] dx;        // signed X delta
      logic [7:0] dy;        // signed Y delta
      logic [7:0] ax;        // |dx|
      logic [7:0] ay;        // |dy|
   } cls_type;

endpackage

`default_nettype wire

>>> sv/mrk_csr.sv
// Configuration registers of the rocker key block.
// Depends on mrk_pkg.
`default_nettype none

module mrk_csr (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_we,
   input  wire [mrk_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire [mrk_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output mrk_pkg::cfg_type                cfg
);
   import mrk_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_MARGIN_MIN:   cfg_in.margin_min    = csr_wdata[6:0];
            CSR_TILT_RATIO:   cfg_in.tilt_ratio    = csr_wdata;
            CSR_REPEAT_NEED:  cfg_in.repeat_needed = csr_wdata[3:0];
            CSR_FIRST_LIMIT:  cfg_in.step_limit[0] = csr_wdata;
            CSR_SECOND_LIMIT: cfg_in.step_limit[1] = csr_wdata;
            CSR_THIRD_LIMIT:  cfg_in.step_limit[2] = csr_wdata;
            CSR_FOURTH_LIMIT: cfg_in.step_limit[3] = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.margin_min    <= RST_MARGIN_MIN;
         cfg_ff.tilt_ratio    <= RST_TILT_RATIO;
         cfg_ff.repeat_needed <= RST_REPEAT_NEED;
         cfg_ff.step_limit[0] <= RST_FIRST_LIMIT;
         cfg_ff.step_limit[1] <= RST_SECOND_LIMIT;
         cfg_ff.step_limit[2] <= RST_THIRD_LIMIT;
         cfg_ff.step_limit[3] <= RST_FOURTH_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> sv/mrk_classify.sv
// Decodes one sensor report and classifies its direction.
// Depends on mrk_pkg; purely combinational.
`default_nettype none

module mrk_classify (
   input  wire                   overflow_flag,
   input  wire                   motion_flag,
   input  wire [7:0]             raw_dx,
   input  wire [7:0]             raw_dy,
   input  wire mrk_pkg::cfg_type cfg,
   output mrk_pkg::cls_type      cls
);
   import mrk_pkg::*;

   logic [7:0]  dx;
   logic [7:0]  dy;
   logic [7:0]  ax;
   logic [7:0]  ay;
   logic [8:0]  diff_xy;
   logic [8:0]  diff_yx;
   logic [8:0]  margin_ext;
   logic [15:0] ax_scaled;
   logic [15:0] ay_scaled;
   logic [15:0] ax_tilt;
   logic [15:0] ay_tilt;
   logic        x_wins;
   logic        y_wins;

   always_comb begin
      dx = raw_dx;
      dy = (raw_dy == DY_NULL) ? 8'd0 : raw_dy;
      // The magnitude of -128 is 128, which still fits in eight unsigned bits.
      ax = dx[7] ? (~dx + 8'd1) : dx;
      ay = dy[7] ? (~dy + 8'd1) : dy;

      diff_xy    = {1'b0, ax} - {1'b0, ay};
      diff_yx    = {1'b0, ay} - {1'b0, ax};
      margin_ext = {2'b00, cfg.margin_min};

      // Products are formed at full 16-bit width so that 128 * 10 does not wrap.
      ax_scaled = {8'd0, ax} * {12'd0, TILT_SCALE};
      ay_scaled = {8'd0, ay} * {12'd0, TILT_SCALE};
      ax_tilt   = {8'd0, ax} * {8'd0, cfg.tilt_ratio};
      ay_tilt   = {8'd0, ay} * {8'd0, cfg.tilt_ratio};

      x_wins = ($signed(diff_xy) > $signed(margin_ext)) && (ax_scaled > ay_tilt);
      y_wins = ($signed(diff_yx) > $signed(margin_ext)) && (ay_scaled > ax_tilt);

      cls.dx    = dx;
      cls.dy    = dy;
      cls.ax    = ax;
      cls.ay    = ay;
      cls.clear = overflow_flag | motion_flag;
      // A magnitude above the margin implies a nonzero delta.
      cls.act   = !overflow_flag && motion_flag &&
                  ((ax > {1'b0, cfg.margin_min}) || (ay > {1'b0, cfg.margin_min}));

      if (x_wins) begin
         cls.cur = dx[7] ? DIR_LEFT : DIR_RIGHT;
      end else if (y_wins) begin
         cls.cur = dy[7] ? DIR_DOWN : DIR_UP;
      end else begin
         cls.cur = DIR_NONE;
      end
   end

endmodule

`default_nettype wire

>>> sv/mrk_track.sv
// Accumulates same-direction motion and decides when a key fires.
// Depends on mrk_pkg; holds the tracking state registers.
`default_nettype none

module mrk_track #(
   parameter int SUM_WIDTH = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   advance,
   input  wire mrk_pkg::cls_type cls,
   input  wire mrk_pkg::cfg_type cfg,
   output mrk_pkg::dir_type      key
);
   import mrk_pkg::*;

   localparam int PAD = SUM_WIDTH + 1 - 8;

   logic signed [SUM_WIDTH-1:0] sum_x_ff, sum_x_in;
   logic signed [SUM_WIDTH-1:0] sum_y_ff, sum_y_in;
   dir_type                     prev_key_ff, prev_key_in;
   dir_type                     prev_dir_ff, prev_dir_in;
   logic [1:0]                  repeat_step_ff, repeat_step_in;
   logic [7:0]                  cross_count_ff, cross_count_in;

   logic                        tracked;
   logic                        new_dir;
   logic                        first;
   logic [SUM_WIDTH-1:0]        base_x;
   logic [SUM_WIDTH-1:0]        base_y;
   logic [7:0]                  base_cross;
   logic [SUM_WIDTH:0]          wide_x;
   logic [SUM_WIDTH:0]          wide_y;
   logic [SUM_WIDTH-1:0]        next_x;
   logic [SUM_WIDTH-1:0]        next_y;
   logic [SUM_WIDTH-1:0]        mag_x;
   logic [SUM_WIDTH-1:0]        mag_y;
   logic [SUM_WIDTH-1:0]        thr_ext;
   logic [7:0]                  thr;
   logic [8:0]                  jump_thr;
   logic                        jump;
   logic                        crossed;
   logic [7:0]                  cross_inc;
   logic                        hit;
   logic                        fire;

   function automatic logic [SUM_WIDTH-1:0] saturate(input logic [SUM_WIDTH:0] s);
      logic [SUM_WIDTH-1:0] r;
      if (s[SUM_WIDTH] != s[SUM_WIDTH-1]) begin
         r = s[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
      end else begin
         r = s[SUM_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic logic [SUM_WIDTH-1:0] magnitude(input logic [SUM_WIDTH-1:0] v);
      return v[SUM_WIDTH-1] ? (~v + SUM_WIDTH'(1)) : v;
   endfunction

   always_comb begin
      tracked = cls.act && (cls.cur != DIR_NONE);
      new_dir = (cls.cur != prev_dir_ff);
      first   = (cls.cur != prev_key_ff);

      // A change of direction restarts the accumulation.
      base_x     = new_dir ? '0 : sum_x_ff;
      base_y     = new_dir ? '0 : sum_y_ff;
      base_cross = new_dir ? 8'd0 : cross_count_ff;

      wide_x = {base_x[SUM_WIDTH-1], base_x} + {{PAD{cls.dx[7]}}, cls.dx};
      wide_y = {base_y[SUM_WIDTH-1], base_y} + {{PAD{cls.dy[7]}}, cls.dy};
      next_x = saturate(wide_x);
      next_y = saturate(wide_y);
      mag_x  = magnitude(next_x);
      mag_y  = magnitude(next_y);

      thr      = first ? cfg.step_limit[0] : cfg.step_limit[repeat_step_ff];
      thr_ext  = {{(SUM_WIDTH-8){1'b0}}, thr};
      jump_thr = {thr, 1'b0};
      // A large single jump only counts toward a key in a new direction.
      jump     = first && (({1'b0, cls.ax} > jump_thr) || ({1'b0, cls.ay} > jump_thr));
      crossed  = (mag_x > thr_ext) || (mag_y > thr_ext);

      cross_inc = (base_cross == CROSS_MAX) ? CROSS_MAX : base_cross + 8'd1;
      hit       = crossed && (cross_inc >= {4'd0, cfg.repeat_needed});
      fire      = tracked && (jump || hit);
      key       = fire ? cls.cur : DIR_NONE;

      sum_x_in       = sum_x_ff;
      sum_y_in       = sum_y_ff;
      prev_key_in    = prev_key_ff;
      prev_dir_in    = prev_dir_ff;
      repeat_step_in = repeat_step_ff;
      cross_count_in = cross_count_ff;

      if (advance && tracked) begin
         if (fire) begin
            prev_key_in    = cls.cur;
            prev_dir_in    = DIR_NONE;
            sum_x_in       = '0;
            sum_y_in       = '0;
            cross_count_in = 8'd0;
            if (first) begin
               repeat_step_in = 2'd1;
            end else if (repeat_step_ff != STEP_LAST) begin
               repeat_step_in = repeat_step_ff + 2'd1;
            end
         end else begin
            prev_dir_in    = cls.cur;
            sum_x_in       = next_x;
            sum_y_in       = next_y;
            cross_count_in = crossed ? cross_inc : base_cross;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff       <= '0;
         sum_y_ff       <= '0;
         prev_key_ff    <= DIR_NONE;
         prev_dir_ff    <= DIR_NONE;
         repeat_step_ff <= 2'd0;
         cross_count_ff <= 8'd0;
      end else begin
         sum_x_ff       <= sum_x_in;
         sum_y_ff       <= sum_y_in;
         prev_key_ff    <= prev_key_in;
         prev_dir_ff    <= prev_dir_in;
         repeat_step_ff <= repeat_step_in;
         cross_count_ff <= cross_count_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/motion_to_rocker_key.sv
// Motion-to-rocker-key block: turns optical sensor motion reports into key codes.
// Top level; instantiates mrk_csr, mrk_classify and mrk_track from mrk_pkg.
//
// Usage: each beat on the req_ channel carries one sensor report (status flags
// on req_tuser, raw X/Y delta bytes on req_tdata). Every report yields exactly
// one beat on the rsp_ channel with a key code and a clear request.
// The report is captured in an input register; decoding, classification and
// the accumulate/threshold decision are done in one pass of logic from there
// into the result register, which also updates the tracking state.
// A report moves from the input register into the result register, which drives
// rsp_tvalid, as soon as the result register is empty or being read.
// Throughput: one report per cycle while rsp_tready is high, set by the update
// of the accumulators and counters, which each report reads and writes.
// When the receiver holds rsp_tready low, the result register keeps its beat,
// the input register still accepts one more report, and req_tready drops only
// once both are full; no beat is lost or repeated.
// Reset (synchronous, active high) empties both registers, zeroes the
// accumulators and key history, and loads the default configuration.
// Configuration is written through csr_we/csr_addr/csr_wdata, one register per
// cycle, while no report is in flight.
`default_nettype none

`include "assert_macros.svh"

module motion_to_rocker_key #(
   parameter int SUM_WIDTH = 16
) (
   input  wire                             clock,
   input  wire                             reset,
   // Report channel.
   input  wire                             req_tvalid,
   output logic                            req_tready,
   input  wire [15:0]                      req_tdata,  // raw_dx[7:0], raw_dy[15:8]
   input  wire [1:0]                       req_tuser,  // overflow_flag[0], motion_flag[1]
   // Key channel.
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [7:0]                      rsp_tdata,  // key_dir[2:0], clear_request[3], 0
   // Configuration port.
   input  wire                             csr_we,
   input  wire [mrk_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire [mrk_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mrk_pkg::*;

   cfg_type     cfg;
   cls_type     cls;
   dir_type     key;

   // Input register.
   logic        s1_valid_ff, s1_valid_in;
   logic [15:0] s1_data_ff, s1_data_in;
   logic [1:0]  s1_user_ff, s1_user_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   dir_type     rsp_key_ff, rsp_key_in;
   logic        rsp_clear_ff, rsp_clear_in;

   logic        s1_move;
   logic        req_take;

   mrk_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mrk_classify u_classify (
      .overflow_flag (s1_user_ff[0]),
      .motion_flag   (s1_user_ff[1]),
      .raw_dx        (s1_data_ff[7:0]),
      .raw_dy        (s1_data_ff[15:8]),
      .cfg           (cfg),
      .cls           (cls)
   );

   // Tracking state advances only when a tracked report moves into the result register.
   mrk_track #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_track (
      .clock   (clock),
      .reset   (reset),
      .advance (s1_move),
      .cls     (cls),
      .cfg     (cfg),
      .key     (key)
   );

   always_comb begin
      s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready = !s1_valid_ff || s1_move;
      req_take   = req_tvalid && req_tready;

      s1_valid_in = req_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      s1_data_in  = req_take ? req_tdata : s1_data_ff;
      s1_user_in  = req_take ? req_tuser : s1_user_ff;

      rsp_valid_in = s1_move ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_key_in   = s1_move ? key : rsp_key_ff;
      rsp_clear_in = s1_move ? cls.clear : rsp_clear_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff   <= s1_data_in;
      s1_user_ff   <= s1_user_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_clear_ff <= rsp_clear_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_clear_ff, rsp_key_ff};

   // A fired key always comes from a motion report, which always asks for a clear.
   `ASSERT_IMPLY(a_key_implies_clear, clock, reset,
      rsp_tvalid && (rsp_tdata[2:0] != DIR_NONE), rsp_tdata[3])

   // Back-pressure reaches the report channel only when both registers are full.
   `ASSERT_IMPLY(a_ready_only_on_stall, clock, reset,
      !req_tready, rsp_tvalid && !rsp_tready)

   // A report held in the input register during a stall keeps its contents.
   `ASSERT_NEXT(a_input_held, clock, reset,
      s1_valid_ff && !s1_move, s1_valid_ff && $stable(s1_data_ff) && $stable(s1_user_ff))

   // Nothing enters the result register without a report behind it.
   `ASSERT_NEXT(a_result_from_input, clock, reset,
      !s1_valid_ff && !rsp_valid_ff, !rsp_valid_ff)

endmodule

`default_nettype wire
